@@ src/slfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared widths and sync codes for the sync/length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

  localparam int BYTE_W = 8;   // received byte and payload byte
  localparam int POS_W  = 5;   // byte position field
  localparam int FLEN_W = 6;   // frame length field

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hFF;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [FLEN_W-1:0] flen_t;

endpackage : slfr_pkg

@@ src/slfr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfr_if
// Valid/ready channels: received bytes in, payload bytes out.
// ----------------------------------------------------------------------------
interface slfr_in_if;
  import slfr_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface : slfr_in_if

interface slfr_out_if;
  import slfr_pkg::*;

  logic  valid;
  logic  ready;
  byte_t payload_byte;
  pos_t  byte_position;
  flen_t frame_length;
  logic  last;

  modport source (output valid, output payload_byte, output byte_position,
                  output frame_length, output last, input ready);
  modport sink   (input valid, input payload_byte, input byte_position,
                  input frame_length, input last, output ready);
endinterface : slfr_out_if

@@ src/sync_length_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_receiver
// Recovers 0xFF 0xAA <len> <payload> frames from a byte stream.
// ----------------------------------------------------------------------------
// Usage: while parsing, one received byte is taken per clock (sync, length
// and payload bytes alike). Payload bytes go to a MAX_PAYLOAD x 8 RAM. When
// the byte that completes a frame is taken, input stalls and the frame is
// replayed from the RAM, one result per payload byte with its position, the
// frame length and a last flag. The first byte is read from RAM in ST_RD and
// loaded into the output register in ST_LOAD; each later byte is read as the
// previous one is taken, then loaded in ST_LOAD. Input stays held off until
// the last result of a frame is taken. A wrong second sync byte, a length of
// zero or a length above MAX_PAYLOAD drops back to the sync hunt without any
// result.
module sync_length_frame_receiver #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  slfr_in_if.sink    in_ch,
  slfr_out_if.source out_ch
);
  import slfr_pkg::*;

  localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [2:0] {
    ST_HUNT, ST_CHECK, ST_LEN, ST_DATA, ST_RD, ST_LOAD, ST_SHOW
  } state_t;

  state_t           state_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] cnt_r;
  logic [AW-1:0]    idx_r;
  logic             out_valid_r;
  byte_t            out_byte_r;
  pos_t             out_pos_r;
  flen_t            out_len_r;
  logic             out_last_r;

  logic             in_fire;
  logic             len_ok;
  logic [LEN_W-1:0] cnt_inc;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  byte_t            ram_rdata;

  assign in_ch.ready = (state_r inside {ST_HUNT, ST_CHECK, ST_LEN, ST_DATA});
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign len_ok      = (in_ch.rx_byte != '0) &&
                       ({1'b0, in_ch.rx_byte} <= 9'(MAX_PAYLOAD));
  assign cnt_inc     = cnt_r + 1'b1;

  // read the first byte from ST_RD; next bytes are prefetched as soon as
  // the current one is taken
  assign ram_re    = (state_r == ST_RD) ||
                     ((state_r == ST_SHOW) && out_ch.ready && !out_last_r);
  assign ram_raddr = (state_r == ST_SHOW) ? AW'(idx_r + 1'b1) : idx_r;

  slfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (in_fire && (state_r == ST_DATA)),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_ch.rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      len_r       <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_HUNT: begin
          if (in_fire && (in_ch.rx_byte == SYNC_FIRST)) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (in_fire) begin
            state_r <= (in_ch.rx_byte == SYNC_SECOND) ? ST_LEN : ST_HUNT;
          end
        end
        ST_LEN: begin
          if (in_fire) begin
            if (len_ok) begin
              len_r   <= LEN_W'(in_ch.rx_byte);
              cnt_r   <= '0;
              state_r <= ST_DATA;
            end else begin
              state_r <= ST_HUNT;
            end
          end
        end
        ST_DATA: begin
          if (in_fire) begin
            cnt_r <= cnt_inc;
            if (cnt_inc == len_r) begin
              idx_r   <= '0;
              state_r <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          out_byte_r  <= ram_rdata;
          out_pos_r   <= POS_W'(idx_r);
          out_len_r   <= FLEN_W'(len_r);
          out_last_r  <= ((LEN_W'(idx_r) + 1'b1) == len_r);
          out_valid_r <= 1'b1;
          state_r     <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= ST_HUNT;
            end else begin
              idx_r   <= AW'(idx_r + 1'b1);
              state_r <= ST_LOAD;
            end
          end
        end
        default: begin
          state_r     <= ST_HUNT;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.payload_byte  = out_byte_r;
  assign out_ch.byte_position = out_pos_r;
  assign out_ch.frame_length  = out_len_r;
  assign out_ch.last          = out_last_r;

endmodule : sync_length_frame_receiver

@@ src/slfr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module slfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule : slfr_ram

@@ src/slfr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module slfr_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input slfr_pkg::byte_t      out_payload_byte,
  input slfr_pkg::pos_t       out_byte_position,
  input slfr_pkg::flen_t      out_frame_length,
  input logic                 out_last
);
  import slfr_pkg::*;

  flen_t len_m1;
  assign len_m1 = out_frame_length - 1'b1;

  // results are held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte) &&
    $stable(out_byte_position) && $stable(out_frame_length) && $stable(out_last))
    else $error("result changed while stalled");

  // input is stalled for the whole replay of a frame
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("input taken during frame replay");

  // last flag sits on the byte at position length-1
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_byte_position == len_m1[POS_W-1:0])
    else $error("last flag on wrong position");

  // positions step by one within a frame
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last ##2 out_valid |->
    out_byte_position == $past(out_byte_position, 2) + 1'b1)
    else $error("byte position did not advance");

  // frame ends: next cycle no result, input open again
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("frame end not followed by return to parsing");

endmodule : slfr_checker

bind sync_length_frame_receiver slfr_checker u_slfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_payload_byte  (out_ch.payload_byte),
  .out_byte_position (out_ch.byte_position),
  .out_frame_length  (out_ch.frame_length),
  .out_last          (out_ch.last)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync/length frame receiver. Byte streams with
// good frames, broken headers and noise go in through the valid/ready input;
// a bench-side frame parser predicts every payload transaction, and each one
// that comes out is checked field by field, in order. Bursty input, random
// output stalls and a long output hold-off exercise the back-pressure paths.
// ----------------------------------------------------------------------------
module tb_top;
  import slfr_pkg::*;

  localparam int MAX_PAYLOAD   = 32;
  localparam int SETTLE_CYCLES = 40;   // replay latency margin after drain
  localparam int HOLD_CYCLES   = 400;  // long output hold-off
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic [1:0] {
    HUNT_SYNC1, CHECK_SYNC2, TAKE_LENGTH, COLLECT_PAYLOAD
  } rx_phase_t;

  typedef struct {
    byte_t data;
    pos_t  pos;
    flen_t len;
    logic  last;
  } payload_rec_t;

  logic clk;
  logic rst_n;

  slfr_in_if  in_ch ();
  slfr_out_if out_ch ();

  sync_length_frame_receiver #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // frame parser state mirrored on the bench side
  rx_phase_t    rx_phase;
  int           frame_len;
  int           bytes_stored;
  byte_t        payload_mem [MAX_PAYLOAD];
  payload_rec_t expected_payload_q [$];

  int error_count;
  int burst_left;
  bit steady_sender;
  bit hold_req;
  int hold_left;
  int stall_mode;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void parse_rx_byte(byte_t b);
    payload_rec_t rec;
    case (rx_phase)
      HUNT_SYNC1: begin
        if (b == SYNC_FIRST) rx_phase = CHECK_SYNC2;
      end
      // a bad second byte is dropped, even 0xFF does not restart the sync
      CHECK_SYNC2: begin
        rx_phase = (b == SYNC_SECOND) ? TAKE_LENGTH : HUNT_SYNC1;
      end
      TAKE_LENGTH: begin
        if (b >= 1 && b <= MAX_PAYLOAD) begin
          frame_len    = b;
          bytes_stored = 0;
          rx_phase     = COLLECT_PAYLOAD;
        end else begin
          rx_phase = HUNT_SYNC1;
        end
      end
      COLLECT_PAYLOAD: begin
        payload_mem[bytes_stored] = b;
        bytes_stored++;
        if (bytes_stored >= frame_len) begin
          for (int k = 0; k < frame_len; k++) begin
            rec.data = payload_mem[k];
            rec.pos  = pos_t'(k);
            rec.len  = flen_t'(frame_len);
            rec.last = (k == frame_len - 1);
            expected_payload_q.push_back(rec);
          end
          rx_phase = HUNT_SYNC1;
        end
      end
      default: begin
        rx_phase = HUNT_SYNC1;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    payload_rec_t exp_rec;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_payload_q.size() == 0) begin
        flag_error($sformatf("unexpected transaction byte=%02h pos=%0d len=%0d last=%0b",
                             out_ch.payload_byte, out_ch.byte_position,
                             out_ch.frame_length, out_ch.last));
      end else begin
        exp_rec = expected_payload_q.pop_front();
        if (out_ch.payload_byte !== exp_rec.data || out_ch.byte_position !== exp_rec.pos ||
            out_ch.frame_length !== exp_rec.len || out_ch.last !== exp_rec.last) begin
          flag_error($sformatf({"exp byte=%02h pos=%0d len=%0d last=%0b, ",
                                "got byte=%02h pos=%0d len=%0d last=%0b"},
                               exp_rec.data, exp_rec.pos, exp_rec.len, exp_rec.last,
                               out_ch.payload_byte, out_ch.byte_position,
                               out_ch.frame_length, out_ch.last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random stall patterns plus an on-request long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(8, 64);
      end
      stall_left--;
      case (stall_mode)
        0:       out_ch.ready = 1'b1;
        1:       out_ch.ready = ($urandom_range(0, 3) != 0);
        2:       out_ch.ready = $urandom_range(0, 1);
        default: out_ch.ready = ((stall_left % 5) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  task automatic send_rx_byte(byte_t b);
    if (burst_left == 0 && !steady_sender) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.rx_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    parse_rx_byte(b);
  endtask

  task automatic send_frame(int len);
    send_rx_byte(SYNC_FIRST);
    send_rx_byte(SYNC_SECOND);
    send_rx_byte(byte_t'(len));
    repeat (len) send_rx_byte(byte_t'($urandom_range(0, 255)));
  endtask

  // sender stops and waits until every predicted transaction has come out
  task automatic wait_frames_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_payload_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_short_frames();
    // single-byte payload that looks like a sync byte
    send_rx_byte(SYNC_FIRST); send_rx_byte(SYNC_SECOND); send_rx_byte(8'd1);
    send_rx_byte(8'hFF);
    // payload holding the other extreme and the second sync code
    send_rx_byte(SYNC_FIRST); send_rx_byte(SYNC_SECOND); send_rx_byte(8'd2);
    send_rx_byte(8'h00); send_rx_byte(SYNC_SECOND);
  endtask

  task automatic test_bad_headers();
    // zero length
    send_rx_byte(SYNC_FIRST); send_rx_byte(SYNC_SECOND); send_rx_byte(8'd0);
    // one past the store size
    send_rx_byte(SYNC_FIRST); send_rx_byte(SYNC_SECOND); send_rx_byte(8'd33);
    // top length code
    send_rx_byte(SYNC_FIRST); send_rx_byte(SYNC_SECOND); send_rx_byte(8'hFF);
    // repeated first sync byte: second 0xFF is dropped, the 0xAA is hunt noise
    send_rx_byte(SYNC_FIRST); send_rx_byte(SYNC_FIRST); send_rx_byte(SYNC_SECOND);
    send_rx_byte(8'd1); send_rx_byte(8'h55);
    // plain wrong second byte, then a good frame right behind it
    send_rx_byte(SYNC_FIRST); send_rx_byte(8'h00);
    send_frame(3);
  endtask

  task automatic test_longest_frame();
    send_frame(MAX_PAYLOAD);
    wait_frames_drained();
    send_frame(MAX_PAYLOAD);
  endtask

  task automatic test_output_holdoff();
    hold_req = 1'b1;
    steady_sender = 1'b1;
    // input must stall behind the held replay, then resume
    send_frame(4);
    send_frame(6);
    send_frame(1);
    steady_sender = 1'b0;
    wait_frames_drained();
  endtask

  task automatic test_random_stream(int target);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 49) == 0) steady_sender = ~steady_sender;
      if ($urandom_range(0, 59) == 0) wait_frames_drained();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 19))
          0:       len = MAX_PAYLOAD;
          1, 2:    len = $urandom_range(9, MAX_PAYLOAD - 1);
          default: len = $urandom_range(1, 8);
        endcase
        send_frame(len);
        sent += len + 3;
      end else if (pick < 80) begin
        send_rx_byte(byte_t'($urandom_range(0, 255)));
        sent += 1;
      end else begin
        send_rx_byte(SYNC_FIRST);
        case ($urandom_range(0, 2))
          0: begin
            send_rx_byte(byte_t'($urandom_range(0, 8'hA9)));
            sent += 2;
          end
          1: begin
            send_rx_byte(SYNC_SECOND);
            send_rx_byte(byte_t'($urandom_range(MAX_PAYLOAD + 1, 255)));
            sent += 3;
          end
          default: begin
            send_rx_byte(SYNC_SECOND);
            send_rx_byte(8'd0);
            sent += 3;
          end
        endcase
      end
    end
    steady_sender = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    rx_phase      = HUNT_SYNC1;
    frame_len     = 0;
    bytes_stored  = 0;
    error_count   = 0;
    burst_left    = 0;
    steady_sender = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    stall_mode    = 0;
    stall_left    = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_short_frames();
    test_bad_headers();
    wait_frames_drained();
    test_longest_frame();
    test_output_holdoff();
    // directed tests above send about 120 bytes
    test_random_stream(280);

    wait_frames_drained();
    if (error_count == 0 && expected_payload_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule : tb_top

@@ sim.f @@
src/slfr_pkg.sv
src/slfr_if.sv
src/slfr_ram.sv
src/sync_length_frame_receiver.sv
src/slfr_checker.sv
bench/tb_top.sv
